[design/skyline_window_filter_core_assert.svh]
// ----------------------------------------------------------------------------
// Skyline window filter assertion macros
// Shared property templates for the concurrent checks of the filter core.
// ----------------------------------------------------------------------------
`ifndef SKYLINE_WINDOW_FILTER_CORE_ASSERT_SVH
`define SKYLINE_WINDOW_FILTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/swf_pkg.sv]
// ----------------------------------------------------------------------------
// Skyline window filter package
// Widths, register addresses, state encoding and cell control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swf_pkg;

  localparam int ID_W    = 16;
  localparam int COORD_W = 32;
  localparam int DIMS_W  = 4;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Word index of the dimension count register (paddr bit 2).
  localparam logic REG_ACTIVE_DIMS = 1'b0;

  localparam logic [DIMS_W-1:0] ACTIVE_DIMS_RST = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_PACK = 4'b0100,
    ST_EMIT = 4'b1000
  } swf_state_t;

  // Per-cell command: take the upper neighbour, load the new point, or drop.
  typedef struct packed {
    logic shift;
    logic load;
    logic kill;
  } swf_cell_ctrl_t;

endpackage

[design/swf_cell.sv]
// ----------------------------------------------------------------------------
// Skyline window cell
// Holds one window entry and tests it against the broadcast point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swf_cell #(
  parameter int MAX_DIMS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  swf_pkg::swf_cell_ctrl_t                     ctrl,
  input  logic [MAX_DIMS-1:0]                         dim_mask,
  input  logic [swf_pkg::ID_W-1:0]                    pt_id,
  input  logic [MAX_DIMS-1:0][swf_pkg::COORD_W-1:0]   pt_coords,
  input  logic                                        nbr_valid,
  input  logic [swf_pkg::ID_W-1:0]                    nbr_id,
  input  logic [MAX_DIMS-1:0][swf_pkg::COORD_W-1:0]   nbr_coords,
  output logic                                        valid,
  output logic [swf_pkg::ID_W-1:0]                    id,
  output logic [MAX_DIMS-1:0][swf_pkg::COORD_W-1:0]   coords,
  output logic                                        entry_dom,
  output logic                                        new_dom
);

  import swf_pkg::*;

  logic                                valid_r;
  logic                                valid_nxt;
  logic [ID_W-1:0]                     id_r;
  logic [MAX_DIMS-1:0][COORD_W-1:0]    coords_r;
  logic [MAX_DIMS-1:0]                 entry_ge;
  logic [MAX_DIMS-1:0]                 new_ge;

  // Signed compare per coordinate; inactive coordinates always agree.
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      entry_ge[d] = $signed(coords_r[d]) >= $signed(pt_coords[d]);
      new_ge[d]   = $signed(pt_coords[d]) >= $signed(coords_r[d]);
    end
  end

  assign entry_dom = &(entry_ge | ~dim_mask);
  assign new_dom   = &(new_ge | ~dim_mask);

  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      valid_nxt = nbr_valid;
    end else if (ctrl.load) begin
      valid_nxt = 1'b1;
    end else if (ctrl.kill) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      id_r     <= nbr_id;
      coords_r <= nbr_coords;
    end else if (ctrl.load) begin
      id_r     <= pt_id;
      coords_r <= pt_coords;
    end
  end

  assign valid  = valid_r;
  assign id     = id_r;
  assign coords = coords_r;

endmodule

[design/skyline_window_filter_core.sv]
// ----------------------------------------------------------------------------
// Skyline window filter core
// Block-nested-loop skyline over a point stream, built as a chain of cells.
// ----------------------------------------------------------------------------
// Points arrive on the in_ stream, one request per point: the id and the
// coordinates in in_tdata, the end-of-set marker in in_tlast. The block holds
// a window of up to WINDOW_SIZE points in a row of cells, each cell comparing
// its entry against the current point in parallel.
// A point is accepted and then tested for dominance; next, every gap left by
// a removed entry that still has a survivor above it is closed by the
// compaction shift through the chain (the cells above a hole move down one
// place per cycle), and last the point is appended or dropped. in_tready is
// high only while the block is idle.
// On a point with in_tlast set, the window ids leave on the out_ stream in
// window order, one per cycle, from the head cell; out_tlast marks the final
// id and out_tuser carries the overflow flag for the set. A stall on out_tready
// simply holds the head cell until it is taken. The window is empty again and
// the overflow flag clear once the final id has gone.
// Synchronous reset empties the window, clears the overflow flag and sets the
// dimension count to eight. The count is written over the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "skyline_window_filter_core_assert.svh"

module skyline_window_filter_core #(
  parameter int WINDOW_SIZE = 32,
  parameter int MAX_DIMS    = 8
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // Input point stream.
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // point_id [15:0], then coord_0 .. coord_(MAX_DIMS-1), 32 bits each.
  input  logic [swf_pkg::ID_W+MAX_DIMS*swf_pkg::COORD_W-1:0] in_tdata,
  // last_point.
  input  logic                                        in_tlast,
  // Result stream.
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // skyline_id [15:0].
  output logic [swf_pkg::ID_W-1:0]                    out_tdata,
  // last_result.
  output logic                                        out_tlast,
  // overflow [0].
  output logic [0:0]                                  out_tuser,
  // Configuration port.
  input  logic                                        cfg_psel,
  input  logic                                        cfg_penable,
  input  logic                                        cfg_pwrite,
  input  logic [swf_pkg::CFG_AW-1:0]                  cfg_paddr,
  input  logic [swf_pkg::CFG_DW-1:0]                  cfg_pwdata,
  output logic [swf_pkg::CFG_DW-1:0]                  cfg_prdata,
  output logic                                        cfg_pready
);

  import swf_pkg::*;

  localparam logic [DIMS_W-1:0] MAX_DIMS_V = DIMS_W'(MAX_DIMS);

  swf_state_t                        state_r, state_nxt;
  logic [DIMS_W-1:0]                 active_dims_r;
  logic [DIMS_W-1:0]                 dims_eff;
  logic [MAX_DIMS-1:0]               dim_mask;

  logic [ID_W-1:0]                   pt_id_r;
  logic [MAX_DIMS-1:0][COORD_W-1:0]  pt_coords_r;
  logic                              pt_last_r;
  logic                              drop_r, drop_nxt;
  logic                              overflow_r, overflow_nxt;

  logic [WINDOW_SIZE-1:0]            cell_valid;
  logic [WINDOW_SIZE-1:0]            entry_dom;
  logic [WINDOW_SIZE-1:0]            new_dom;
  logic [WINDOW_SIZE:0]              above_ext;
  logic [WINDOW_SIZE:0]              below_ext;
  logic [WINDOW_SIZE-1:0]            valid_above;
  logic [WINDOW_SIZE-1:0]            valid_below;
  logic [WINDOW_SIZE-1:0]            hole_below;
  logic                              pack_needed;
  logic                              any_cover;
  logic                              out_fire;

  logic [ID_W-1:0]                   chain_id     [WINDOW_SIZE+1];
  logic [MAX_DIMS-1:0][COORD_W-1:0]  chain_coords [WINDOW_SIZE+1];
  swf_cell_ctrl_t                    ctrl         [WINDOW_SIZE];

  // --------------------------------------------------------------------------
  // Configuration register. Writes are decoded on the word index only.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DW'(active_dims_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dims_r <= ACTIVE_DIMS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_ACTIVE_DIMS) begin
      active_dims_r <= cfg_pwdata[DIMS_W-1:0];
    end
  end

  // Zero behaves as one dimension, anything above the build limit as the limit.
  always_comb begin
    if (active_dims_r == '0) begin
      dims_eff = DIMS_W'(1);
    end else if (active_dims_r > MAX_DIMS_V) begin
      dims_eff = MAX_DIMS_V;
    end else begin
      dims_eff = active_dims_r;
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      dim_mask[d] = DIMS_W'(d) < dims_eff;
    end
  end

  // --------------------------------------------------------------------------
  // Point register, loaded on each accepted request.
  // --------------------------------------------------------------------------
  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pt_id_r   <= in_tdata[ID_W-1:0];
      pt_last_r <= in_tlast;
      for (int d = 0; d < MAX_DIMS; d++) begin
        pt_coords_r[d] <= in_tdata[ID_W + d*COORD_W +: COORD_W];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Neighbour views of the valid bits. The window is kept as a contiguous run
  // of valid cells from the head, except briefly after entries are removed.
  // --------------------------------------------------------------------------
  assign above_ext   = {1'b0, cell_valid};
  assign below_ext   = {cell_valid, 1'b1};
  assign valid_above = above_ext[WINDOW_SIZE:1];
  assign valid_below = below_ext[WINDOW_SIZE-1:0];
  assign pack_needed = |(~cell_valid & valid_above);
  assign any_cover   = |(cell_valid & entry_dom);

  // A cell moves down when there is a gap at or below it.
  always_comb begin
    hole_below[0] = ~cell_valid[0];
    for (int j = 1; j < WINDOW_SIZE; j++) begin
      hole_below[j] = hole_below[j-1] | ~cell_valid[j];
    end
  end

  assign out_fire = out_tvalid && out_tready;

  // --------------------------------------------------------------------------
  // Sequencer and per-cell commands.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    drop_nxt     = drop_r;
    overflow_nxt = overflow_r;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      ctrl[j] = '0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        // A covered point changes nothing; otherwise the entries it covers go.
        drop_nxt = any_cover;
        for (int j = 0; j < WINDOW_SIZE; j++) begin
          ctrl[j].kill = cell_valid[j] & new_dom[j] & ~any_cover;
        end
        state_nxt = ST_PACK;
      end
      ST_PACK: begin
        if (pack_needed) begin
          for (int j = 0; j < WINDOW_SIZE; j++) begin
            ctrl[j].shift = hole_below[j];
          end
        end else begin
          if (!drop_r) begin
            if (cell_valid[WINDOW_SIZE-1]) begin
              overflow_nxt = 1'b1;
            end
            for (int j = 0; j < WINDOW_SIZE; j++) begin
              ctrl[j].load = ~cell_valid[j] & valid_below[j];
            end
          end
          state_nxt = pt_last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          for (int j = 0; j < WINDOW_SIZE; j++) begin
            ctrl[j].shift = 1'b1;
          end
          if (out_tlast) begin
            overflow_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      drop_r     <= 1'b0;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      drop_r     <= drop_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // The cell chain. The slot above the top cell feeds in an empty entry.
  // --------------------------------------------------------------------------
  assign chain_id[WINDOW_SIZE]     = '0;
  assign chain_coords[WINDOW_SIZE] = '0;

  for (genvar j = 0; j < WINDOW_SIZE; j++) begin : g_cell
    swf_cell #(
      .MAX_DIMS (MAX_DIMS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl[j]),
      .dim_mask   (dim_mask),
      .pt_id      (pt_id_r),
      .pt_coords  (pt_coords_r),
      .nbr_valid  (valid_above[j]),
      .nbr_id     (chain_id[j+1]),
      .nbr_coords (chain_coords[j+1]),
      .valid      (cell_valid[j]),
      .id         (chain_id[j]),
      .coords     (chain_coords[j]),
      .entry_dom  (entry_dom[j]),
      .new_dom    (new_dom[j])
    );
  end

  // --------------------------------------------------------------------------
  // Results leave from the head cell.
  // --------------------------------------------------------------------------
  assign out_tvalid   = (state_r == ST_EMIT);
  assign out_tdata    = chain_id[0];
  assign out_tlast    = ~valid_above[0];
  assign out_tuser[0] = overflow_r;

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  `SWF_ASSERT_NOW(a_idle_packed, state_r == ST_IDLE, !pack_needed,
                  "window has a gap while idle")
  `SWF_ASSERT_NOW(a_emit_nonempty, state_r == ST_EMIT, cell_valid[0],
                  "emitting from an empty window")
  `SWF_ASSERT_NEXT(a_accept_cmp, in_tvalid && in_tready, state_r == ST_CMP,
                   "accepted point not compared next cycle")
  `SWF_ASSERT_NEXT(a_set_done, out_fire && out_tlast,
                   state_r == ST_IDLE && !overflow_r && cell_valid == '0,
                   "window not cleared after the final result")

endmodule

[tb/sv/skyline_window_filter_checker.sv]
// ----------------------------------------------------------------------------
// Skyline window filter checker
// Follows the point, result and register channels of the filter core. It keeps
// its own copy of the skyline window and compares every skyline id that
// leaves the core with the one it has worked out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skyline_window_filter_checker #(
  parameter int WINDOW_SIZE = 32,
  parameter int MAX_DIMS    = 8
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 in_tvalid,
  input  logic                                                 in_tready,
  input  logic [swf_pkg::ID_W+MAX_DIMS*swf_pkg::COORD_W-1:0]   in_tdata,
  input  logic                                                 in_tlast,
  input  logic                                                 out_tvalid,
  input  logic                                                 out_tready,
  input  logic [swf_pkg::ID_W-1:0]                             out_tdata,
  input  logic                                                 out_tlast,
  input  logic [0:0]                                           out_tuser,
  input  logic                                                 cfg_psel,
  input  logic                                                 cfg_penable,
  input  logic                                                 cfg_pwrite,
  input  logic [swf_pkg::CFG_AW-1:0]                           cfg_paddr,
  input  logic [swf_pkg::CFG_DW-1:0]                           cfg_pwdata,
  input  logic [swf_pkg::CFG_DW-1:0]                           cfg_prdata,
  input  logic                                                 cfg_pready,
  output int                                                   fail_count,
  output int                                                   pending
);

  import swf_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
    logic            ovf;
  } skyline_result_t;

  // Shadow of the core's window, in window order.
  logic [ID_W-1:0]   win_id [WINDOW_SIZE];
  coord_t            win_pt [WINDOW_SIZE][MAX_DIMS];
  coord_t            cur_pt [MAX_DIMS];
  int                win_n;
  bit                ovf_seen;
  logic [DIMS_W-1:0] dims_reg;

  skyline_result_t skyline_q [$];

  function automatic int dims_in_use();
    if (dims_reg == '0) return 1;
    if (dims_reg > MAX_DIMS) return MAX_DIMS;
    return int'(dims_reg);
  endfunction

  function automatic bit entry_covers_point(int j, int n);
    for (int d = 0; d < n; d++)
      if (win_pt[j][d] < cur_pt[d]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit point_covers_entry(int j, int n);
    for (int d = 0; d < n; d++)
      if (cur_pt[d] < win_pt[j][d]) return 1'b0;
    return 1'b1;
  endfunction

  // Runs one accepted point through the window and queues the skyline ids
  // that a final point releases.
  task automatic absorb_point(input logic [ID_W+MAX_DIMS*COORD_W-1:0] data,
                              input logic last);
    int n;
    int kept;
    bit dropped;
    skyline_result_t r;
    n = dims_in_use();
    for (int d = 0; d < MAX_DIMS; d++) cur_pt[d] = data[ID_W + d*COORD_W +: COORD_W];
    dropped = 1'b0;
    for (int j = 0; j < win_n; j++)
      if (entry_covers_point(j, n)) dropped = 1'b1;
    if (!dropped) begin
      kept = 0;
      for (int j = 0; j < win_n; j++) begin
        if (!point_covers_entry(j, n)) begin
          win_id[kept] = win_id[j];
          for (int d = 0; d < MAX_DIMS; d++) win_pt[kept][d] = win_pt[j][d];
          kept++;
        end
      end
      win_n = kept;
      if (win_n < WINDOW_SIZE) begin
        win_id[win_n] = data[ID_W-1:0];
        for (int d = 0; d < MAX_DIMS; d++) win_pt[win_n][d] = cur_pt[d];
        win_n++;
      end else begin
        ovf_seen = 1'b1;
      end
    end
    if (last) begin
      for (int j = 0; j < win_n; j++) begin
        r.id   = win_id[j];
        r.last = (j == win_n - 1);
        r.ovf  = ovf_seen;
        skyline_q = {skyline_q, r};
      end
      win_n    = 0;
      ovf_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    skyline_result_t want;
    if (!rst_n) begin
      win_n      = 0;
      ovf_seen   = 1'b0;
      dims_reg   = ACTIVE_DIMS_RST;
      fail_count = 0;
      skyline_q.delete();
      pending   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (skyline_q.size() == 0) begin
          fail_count++;
          $display("%0t: skyline id %h arrived with none expected (last %b, overflow %b)",
                   $time, out_tdata, out_tlast, out_tuser[0]);
        end else begin
          want = skyline_q.pop_front();
          if (out_tdata !== want.id) begin
            fail_count++;
            $display("%0t: skyline id mismatch: expected %h, actual %h",
                     $time, want.id, out_tdata);
          end
          if (out_tlast !== want.last) begin
            fail_count++;
            $display("%0t: last result flag mismatch: expected %b, actual %b",
                     $time, want.last, out_tlast);
          end
          if (out_tuser[0] !== want.ovf) begin
            fail_count++;
            $display("%0t: overflow flag mismatch: expected %b, actual %b",
                     $time, want.ovf, out_tuser[0]);
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[2] == REG_ACTIVE_DIMS) begin
        if (cfg_pwrite) begin
          dims_reg = cfg_pwdata[DIMS_W-1:0];
        end else if (cfg_prdata !== CFG_DW'(dims_reg)) begin
          fail_count++;
          $display("%0t: active_dims read mismatch: expected %h, actual %h",
                   $time, CFG_DW'(dims_reg), cfg_prdata);
        end
      end
      if (in_tvalid && in_tready) absorb_point(in_tdata, in_tlast);
      pending <= skyline_q.size();
    end
  end

endmodule

[tb/sv/skyline_window_filter_core_tb.sv]
// ----------------------------------------------------------------------------
// Skyline window filter core testbench
// Drives point sets through the filter core under several dimension counts,
// with random gaps on the point stream and random stalls on the result stream.
// A separate checker predicts the skyline ids; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skyline_window_filter_core_tb;
  import swf_pkg::*;

  localparam int NUM_DIMS    = 8;
  localparam int WIN_ENTRIES = 32;
  localparam int POINT_W     = ID_W + NUM_DIMS * COORD_W;

  // Byte address of the dimension count register.
  localparam logic [CFG_AW-1:0] ADDR_ACTIVE_DIMS = {REG_ACTIVE_DIMS, 2'b00};

  // Idle time, sized on the window depth, that covers a point whose removed
  // entries may still be compacting the window.
  localparam int SETTLE_CYCLES   = WIN_ENTRIES + 8;
  localparam int LONG_HOLD       = 300;
  localparam int ITEMS_PER_PHASE = 40;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // point_id [15:0], then coord_0 .. coord_7, 32 bits each.
  logic [POINT_W-1:0]   in_tdata;
  // last_point.
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  // skyline_id [15:0].
  logic [ID_W-1:0]      out_tdata;
  // last_result.
  logic                 out_tlast;
  // overflow [0].
  logic [0:0]           out_tuser;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [CFG_AW-1:0]    cfg_paddr;
  logic [CFG_DW-1:0]    cfg_pwdata;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  int fail_count;
  int pending;

  // Coordinates of the next point to be offered.
  logic [COORD_W-1:0] pt_c [NUM_DIMS];

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_out = 1'b0;
  // While set, neither side idles.
  bit no_idle = 1'b0;

  // Dimension counts used by the random phases; zero and fifteen check that
  // out-of-range counts are clamped to one and to eight.
  logic [DIMS_W-1:0] dims_plan [8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd3, 4'd7};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  skyline_window_filter_core #(
    .WINDOW_SIZE (WIN_ENTRIES),
    .MAX_DIMS    (NUM_DIMS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  skyline_window_filter_checker #(
    .WINDOW_SIZE (WIN_ENTRIES),
    .MAX_DIMS    (NUM_DIMS)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Mostly no gap, often a short one and now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Small values make dominance and ties common; the rest reach the extremes
  // and every bit of the word.
  function automatic logic [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 8) - 32'd4;
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  task automatic fill_coords(input logic [COORD_W-1:0] value);
    for (int d = 0; d < NUM_DIMS; d++) pt_c[d] = value;
  endtask

  // Offers one point and returns at the edge where the request was taken, or
  // at the end of the gap that follows it. Must be called on a rising edge.
  task automatic send_point(input logic [ID_W-1:0] pid, input bit last);
    logic [POINT_W-1:0] word;
    int gap;
    word = '0;
    word[ID_W-1:0] = pid;
    for (int d = 0; d < NUM_DIMS; d++) word[ID_W + d*COORD_W +: COORD_W] = pt_c[d];
    in_tdata  <= word;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One APB-style transfer: setup cycle, then access until pready.
  task automatic cfg_access(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering points and waits until every predicted skyline id has been
  // taken. The checker publishes its count from a register, hence the first
  // edge before it is looked at. The settle cycles cover a point that gave no
  // result but may still be compacting the window.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Short directed sets under the reset dimension count of eight.
  task automatic run_directed();
    // A point at the top corner sweeps out the one below it, an exact copy of
    // it is dropped, and a final point inside the window is dropped as well.
    fill_coords(32'h8000_0000);
    send_point(16'h0000, 1'b0);
    fill_coords(32'h7FFF_FFFF);
    send_point(16'hFFFF, 1'b0);
    send_point(16'h1234, 1'b0);
    fill_coords(32'h0000_0000);
    send_point(16'h0001, 1'b1);

    // Three mutually incomparable points, then one that removes only the
    // middle entry, so the order of the survivors must hold; the final point
    // is incomparable with all of them and is appended.
    fill_coords(32'h0000_0000);
    send_point(16'd10, 1'b0);
    pt_c[0] = 32'd1;
    pt_c[1] = -32'sd1;
    send_point(16'd11, 1'b0);
    pt_c[0] = 32'd2;
    pt_c[1] = -32'sd2;
    send_point(16'd12, 1'b0);
    pt_c[0] = 32'd1;
    pt_c[1] = -32'sd1;
    pt_c[2] = 32'h0005_0000;
    send_point(16'd13, 1'b0);
    fill_coords(32'h8000_0000);
    pt_c[0] = 32'h7FFF_FFFF;
    send_point(16'd14, 1'b1);

    // A lone final point with alternating extreme coordinates.
    for (int d = 0; d < NUM_DIMS; d++) pt_c[d] = d[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_point(16'h8000, 1'b1);

    // Minus one sits below zero: the compare must be signed.
    fill_coords(32'hFFFF_FFFF);
    send_point(16'd1, 1'b0);
    fill_coords(32'h0000_0000);
    send_point(16'd2, 1'b1);

    // A later duplicate is dominated by the earlier copy.
    fill_coords(32'h0005_0000);
    send_point(16'd3, 1'b0);
    send_point(16'd4, 1'b1);
  endtask

  // Random point sets, each closed by a final point. About one set in eight is
  // a long chain of incomparable points (rising in coord_0, falling in
  // coord_1), which can fill the window and drive it into overflow.
  task automatic run_random(input int quota);
    int sent;
    int size;
    bit chain;
    logic [COORD_W-1:0] base0;
    logic [COORD_W-1:0] base1;
    logic [COORD_W-1:0] stride;
    sent = 0;
    while (sent < quota) begin
      chain  = ($urandom_range(0, 7) == 0);
      size   = chain ? $urandom_range(30, 40) : $urandom_range(1, 10);
      base0  = $urandom_range(0, 20000) - 32'd20000;
      base1  = $urandom_range(0, 20000);
      stride = $urandom_range(1, 1000);
      for (int i = 0; i < size; i++) begin
        for (int d = 0; d < NUM_DIMS; d++) pt_c[d] = rand_coord();
        if (chain) begin
          pt_c[0] = base0 + COORD_W'(i) * stride;
          pt_c[1] = base1 - COORD_W'(i) * stride;
        end
        send_point(ID_W'($urandom_range(0, 65535)), i == size - 1);
      end
      sent += size;
    end
  endtask

  // Result side: bursts of ready and stalls of random length, a long hold-off
  // when asked for one, and ready held high while idling is switched off.
  initial begin
    int ready_left;
    int stall_left;
    ready_left = 0;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out = 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else if (ready_left > 0) begin
        out_tready <= 1'b1;
        ready_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        ready_left = $urandom_range(0, 11);
        stall_left = pick_gap();
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The register must read back its reset value before anything is written.
    cfg_access(1'b0, ADDR_ACTIVE_DIMS, '0);
    run_directed();

    // Each phase starts from an empty window: the sender waits until every
    // expected result has come before the dimension count is changed.
    for (int p = 0; p < 8; p++) begin
      drain_results();
      no_idle = (p == 1);
      cfg_access(1'b1, ADDR_ACTIVE_DIMS, CFG_DW'(dims_plan[p]));
      cfg_access(1'b0, ADDR_ACTIVE_DIMS, '0);
      // The receiver holds off for a long stretch while points keep coming,
      // so the emission backs up and the input request is held off.
      if (p == 3) hold_out = 1'b1;
      run_random(ITEMS_PER_PHASE);
    end
    drain_results();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
